/* src/cbm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

    // Widths of the bus fields and of the stored registers
    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int MEM_ADDR_W  = 19;
    localparam int MAX_BANK_W  = 5;
    localparam int BANK_BITS_DEF = 5;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_INDEX_W = 1;

    typedef enum logic [1:0] {
        CMD_REG_WRITE = 2'd0,
        CMD_REG_READ  = 2'd1,
        CMD_MEM_READ  = 2'd2,
        CMD_MEM_WRITE = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        TGT_HOST  = 2'd0,
        TGT_ROM   = 2'd1,
        TGT_SRAM  = 2'd2,
        TGT_REG   = 2'd3
    } target_t;

    // Mode register bits 7:6
    typedef enum logic [1:0] {
        MAP_16K     = 2'd0,
        MAP_8K      = 2'd1,
        MAP_ULTIMAX = 2'd2,
        MAP_OFF     = 2'd3
    } map_t;

    // Register offsets (address bits 1:0)
    localparam logic [1:0] OFF_BANK = 2'd2;
    localparam logic [1:0] OFF_MODE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANK_MASK = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIDES_READS   = 1'd1;

    // Mode register bit positions
    localparam int MODE_HIDE_BIT = 3;
    localparam int MODE_WREN_BIT = 4;
    localparam int MODE_SRAM_BIT = 5;

    // Host address windows by address bits 15:13
    localparam logic [2:0] WIN_0000 = 3'b000;
    localparam logic [2:0] WIN_4000 = 3'b010;
    localparam logic [2:0] WIN_6000 = 3'b011;
    localparam logic [2:0] WIN_8000 = 3'b100;
    localparam logic [2:0] WIN_A000 = 3'b101;
    localparam logic [2:0] WIN_E000 = 3'b111;

    localparam logic [DATA_W-1:0] HIDDEN_READ = 8'hFF;

    typedef struct packed {
        logic [DATA_W-1:0]     register_data;
        target_t               target;
        logic [MEM_ADDR_W-1:0] memory_address;
        logic                  memory_write;
        logic                  host_ram_write;
        map_t                  map_mode;
        logic                  fake_ultimax;
    } result_t;

    typedef struct packed {
        logic bank_we;
        logic mode_we;
    } reg_update_t;

endpackage

`default_nettype wire

/* src/cbm_decode.sv */
`timescale 1ns / 1ps
`default_nettype none

// Decode one bus access against the current bank and mode registers.
module cbm_decode #(
    parameter int BANK_BITS = cbm_pkg::BANK_BITS_DEF
) (
    input  wire cbm_pkg::command_t              command,
    input  wire logic [cbm_pkg::ADDR_W-1:0]     address,
    input  wire logic [cbm_pkg::DATA_W-1:0]     write_data,
    input  wire logic [BANK_BITS-1:0]           bank,
    input  wire logic [cbm_pkg::DATA_W-1:0]     mode,
    input  wire logic [cbm_pkg::MAX_BANK_W-1:0] rom_bank_mask,
    input  wire logic                           hides_reads,
    output cbm_pkg::result_t                    result,
    output cbm_pkg::reg_update_t                update
);

    logic [1:0]                     offset;
    logic                           visible;
    cbm_pkg::map_t                  cur_map;
    logic                           cur_fake;
    logic [2:0]                     window;
    logic                           hit;
    logic                           high;
    logic [cbm_pkg::MAX_BANK_W-1:0] bank_ext;
    logic [cbm_pkg::MAX_BANK_W-1:0] bank_sel;
    logic [cbm_pkg::DATA_W-1:0]     mode_after;

    assign offset   = address[1:0];
    assign visible  = !mode[cbm_pkg::MODE_HIDE_BIT];
    assign cur_map  = cbm_pkg::map_t'(mode[7:6]);
    assign cur_fake = mode[cbm_pkg::MODE_WREN_BIT] && (cur_map != cbm_pkg::MAP_OFF);
    assign window   = address[15:13];
    assign bank_ext = cbm_pkg::MAX_BANK_W'(bank);

    always_comb begin
        result                = '0;
        result.register_data  = cbm_pkg::HIDDEN_READ;
        result.target         = cbm_pkg::TGT_HOST;
        update                = '0;
        hit                   = 1'b0;
        high                  = 1'b0;
        bank_sel              = bank_ext;
        case (command)
            cbm_pkg::CMD_REG_WRITE: begin
                result.target = cbm_pkg::TGT_REG;
                update.bank_we = visible && (offset == cbm_pkg::OFF_BANK);
                update.mode_we = visible && (offset == cbm_pkg::OFF_MODE);
            end
            cbm_pkg::CMD_REG_READ: begin
                result.target = cbm_pkg::TGT_REG;
                if (!hides_reads && visible) begin
                    if (offset == cbm_pkg::OFF_BANK) begin
                        result.register_data = cbm_pkg::DATA_W'(bank);
                    end else if (offset == cbm_pkg::OFF_MODE) begin
                        result.register_data = mode;
                    end
                end
            end
            cbm_pkg::CMD_MEM_READ: begin
                case (window)
                    cbm_pkg::WIN_E000: begin
                        hit  = (cur_map == cbm_pkg::MAP_ULTIMAX);
                        high = 1'b1;
                    end
                    cbm_pkg::WIN_A000: begin
                        hit  = (cur_map == cbm_pkg::MAP_16K);
                        high = 1'b1;
                    end
                    cbm_pkg::WIN_8000: begin
                        hit  = (cur_map != cbm_pkg::MAP_OFF);
                    end
                    default: begin
                        hit  = 1'b0;
                    end
                endcase
                if (hit) begin
                    if (mode[cbm_pkg::MODE_SRAM_BIT]) begin
                        result.target = cbm_pkg::TGT_SRAM;
                    end else begin
                        result.target = cbm_pkg::TGT_ROM;
                        bank_sel      = bank_ext & rom_bank_mask;
                    end
                end
            end
            default: begin
                if (cur_fake) begin
                    // Host RAM sees every write in 1000-7FFF
                    result.host_ram_write = !address[15] && (address[14:12] != 3'b000);
                    case (window)
                        cbm_pkg::WIN_4000: hit = 1'b1;
                        cbm_pkg::WIN_6000: begin
                            hit  = 1'b1;
                            high = 1'b1;
                        end
                        cbm_pkg::WIN_8000: hit = 1'b1;
                        cbm_pkg::WIN_A000, cbm_pkg::WIN_E000: begin
                            hit  = 1'b1;
                            high = 1'b1;
                        end
                        default: hit = 1'b0;
                    endcase
                    if (hit) begin
                        result.target       = cbm_pkg::TGT_SRAM;
                        result.memory_write = 1'b1;
                    end
                end
            end
        endcase
        if (hit) begin
            result.memory_address = {bank_sel, high, address[12:0]};
        end
        mode_after            = update.mode_we ? write_data : mode;
        result.map_mode       = cbm_pkg::map_t'(mode_after[7:6]);
        result.fake_ultimax   = mode_after[cbm_pkg::MODE_WREN_BIT]
                                && (mode_after[7:6] != cbm_pkg::MAP_OFF);
    end

endmodule

`default_nettype wire

/* src/cartridge_bank_mapper.sv */
`timescale 1ns / 1ps
`default_nettype none

// Banking cartridge mapper: one host bus access per word.
//
// Input channel (s_*): command, address and write data of one access.
// Result channel (m_*): register read data, target (host, ROM, SRAM or
// register), 19-bit ROM/SRAM address, SRAM and host RAM write flags, and
// the mapping in force after the access.
// Configuration port (cfg_*): ROM bank mask and the hidden-read variant;
// write only while no word is in flight.
//
// Pipeline: an accepted word passes through the input register, the decode
// and the result register. Throughput: one word per cycle while m_ready
// stays high, set by the single decode pass between the two registers; the bank
// and mode registers update as a word leaves the input register, so the
// following word already sees them.
// Reset (aresetn low, synchronous): both pipeline stages empty, bank and
// mode registers cleared (16K ROM mapping), mask 31, variant off.
// Stall: while m_ready is low the result is held; one more word is taken
// into the input register, after which s_ready drops.
module cartridge_bank_mapper #(
    parameter int BANK_BITS = cbm_pkg::BANK_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [1:0]                         s_command,
    input  wire logic [cbm_pkg::ADDR_W-1:0]         s_address,
    input  wire logic [cbm_pkg::DATA_W-1:0]         s_write_data,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [cbm_pkg::DATA_W-1:0]              m_register_data,
    output logic [1:0]                              m_target,
    output logic [cbm_pkg::MEM_ADDR_W-1:0]          m_memory_address,
    output logic                                    m_memory_write,
    output logic                                    m_host_ram_write,
    output logic [1:0]                              m_map_mode,
    output logic                                    m_fake_ultimax,

    input  wire logic                               cfg_write_enable,
    input  wire logic [cbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [cbm_pkg::CFG_DATA_W-1:0]     cfg_write_data
);

    // Input register stage
    logic                               in_valid_reg;
    cbm_pkg::command_t                  in_command_reg;
    logic [cbm_pkg::ADDR_W-1:0]         in_address_reg;
    logic [cbm_pkg::DATA_W-1:0]         in_data_reg;

    // Mapper state and configuration
    logic [BANK_BITS-1:0]               bank_reg;
    logic [BANK_BITS-1:0]               bank_next;
    logic [cbm_pkg::DATA_W-1:0]         mode_reg;
    logic [cbm_pkg::DATA_W-1:0]         mode_next;
    logic [cbm_pkg::MAX_BANK_W-1:0]     rom_mask_reg;
    logic                               hides_reg;

    // Result register stage
    logic                               out_valid_reg;
    cbm_pkg::result_t                   out_reg;

    cbm_pkg::result_t                   dec_result;
    cbm_pkg::reg_update_t               dec_update;
    logic                               out_free;
    logic                               advance;
    logic                               take_in;

    // The result register is free when empty or being emptied this cycle
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign take_in  = s_valid && s_ready;

    cbm_decode #(
        .BANK_BITS(BANK_BITS)
    ) u_decode (
        .command       (in_command_reg),
        .address       (in_address_reg),
        .write_data    (in_data_reg),
        .bank          (bank_reg),
        .mode          (mode_reg),
        .rom_bank_mask (rom_mask_reg),
        .hides_reads   (hides_reg),
        .result        (dec_result),
        .update        (dec_update)
    );

    // Register writes commit only as the word moves on, never while it waits
    always_comb begin
        bank_next = bank_reg;
        mode_next = mode_reg;
        if (advance && dec_update.bank_we) begin
            bank_next = in_data_reg[BANK_BITS-1:0];
        end
        if (advance && dec_update.mode_we) begin
            mode_next = in_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            bank_reg      <= '0;
            mode_reg      <= '0;
            rom_mask_reg  <= '1;
            hides_reg     <= 1'b0;
        end else begin
            // Hold the input word until the result register can take it
            if (take_in) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            bank_reg <= bank_next;
            mode_reg <= mode_next;
            if (cfg_write_enable) begin
                case (cfg_index)
                    cbm_pkg::CFG_ROM_BANK_MASK: rom_mask_reg <= cfg_write_data;
                    cbm_pkg::CFG_HIDES_READS:   hides_reg    <= cfg_write_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge aclk) begin
        if (take_in) begin
            in_command_reg <= cbm_pkg::command_t'(s_command);
            in_address_reg <= s_address;
            in_data_reg    <= s_write_data;
        end
        if (advance) begin
            out_reg <= dec_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_register_data  = out_reg.register_data;
    assign m_target         = out_reg.target;
    assign m_memory_address = out_reg.memory_address;
    assign m_memory_write   = out_reg.memory_write;
    assign m_host_ram_write = out_reg.host_ram_write;
    assign m_map_mode       = out_reg.map_mode;
    assign m_fake_ultimax   = out_reg.fake_ultimax;

    // Once hidden, the registers stay frozen until reset
    a_hidden_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg[cbm_pkg::MODE_HIDE_BIT] |=> (mode_reg == $past(mode_reg))
                                             && (bank_reg == $past(bank_reg)))
        else $error("mapper registers changed while hidden");

    // SRAM writes only ever target SRAM
    a_write_sram: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_memory_write) |-> (m_target == cbm_pkg::TGT_SRAM))
        else $error("memory write flagged on a non-SRAM target");

    // Host RAM write-through only happens with fake ultimax on
    a_host_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_host_ram_write) |-> m_fake_ultimax)
        else $error("host RAM write without fake ultimax");

    // A stalled result is held in place
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(out_reg)))
        else $error("result changed while stalled");

endmodule

`default_nettype wire
